@@ sv/sliding_window_median_unit_defines.svh @@
// Assertion macros for the sliding window median unit
`ifndef SLIDING_WINDOW_MEDIAN_UNIT_DEFINES_SVH
`define SLIDING_WINDOW_MEDIAN_UNIT_DEFINES_SVH

// Antecedent implies consequent in the same cycle
`define SWM_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Antecedent implies consequent in the next cycle
`define SWM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/swm_pkg.sv @@
// Shared constants and types for the sliding window median unit
`default_nettype none

package swm_pkg;

    localparam int WINDOW_LEN = 7;
    localparam int SAMPLE_W   = 16;
    localparam int THR_W      = 16;
    localparam int IDX_W      = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
    localparam int CNT_W      = $clog2(WINDOW_LEN + 1);
    localparam int MID_IDX    = WINDOW_LEN / 2;

    localparam int PADDR_W    = 3;
    localparam int PDATA_W    = 32;
    localparam int REG_IDX_W  = PADDR_W - 2;

    localparam logic [REG_IDX_W-1:0] REG_CHANGE_THRESHOLD = '0;
    localparam logic [THR_W-1:0]     THR_RESET            = 16'd3;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_OLD  = 5'b00010,
        S_LOAD = 5'b00100,
        S_SCAN = 5'b01000,
        S_DONE = 5'b10000
    } t_state;

    typedef struct packed {
        logic                       we;
        logic [IDX_W-1:0]           waddr;
        logic signed [SAMPLE_W-1:0] wdata;
        logic [IDX_W-1:0]           raddr;
    } t_ram_req;

endpackage

`default_nettype wire

@@ sv/swm_ram.sv @@
// Generic single write, single read synchronous RAM with registered read data
`default_nettype none

module swm_ram #(
    parameter int DEPTH = 8,
    parameter int WIDTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

@@ sv/swm_cfg.sv @@
// APB configuration register: median change threshold
`default_nettype none

module swm_cfg (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [swm_pkg::PADDR_W-1:0]       paddr,
    input  wire logic [swm_pkg::PDATA_W-1:0]       pwdata,
    output logic      [swm_pkg::PDATA_W-1:0]       prdata,
    output logic                                   pready,
    output logic      [swm_pkg::THR_W-1:0]         o_threshold
);

    logic [swm_pkg::THR_W-1:0]     r_thr;
    logic [swm_pkg::REG_IDX_W-1:0] reg_idx;
    logic                          thr_sel;

    assign reg_idx = paddr[swm_pkg::PADDR_W-1:2];
    assign thr_sel = (reg_idx == swm_pkg::REG_CHANGE_THRESHOLD);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= swm_pkg::THR_RESET;
        end else if (psel && penable && pwrite && thr_sel) begin
            r_thr <= pwdata[swm_pkg::THR_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (thr_sel) begin
            prdata = {{(swm_pkg::PDATA_W - swm_pkg::THR_W){1'b0}}, r_thr};
        end
    end

    assign pready      = 1'b1;
    assign o_threshold = r_thr;

endmodule

`default_nettype wire

@@ sv/swm_ctrl.sv @@
// Sequencer: ring buffer update, sorted-window merge pass and result register
`default_nettype none

module swm_ctrl (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_in_valid,
    output logic                                      o_in_stall,
    input  wire logic signed [swm_pkg::SAMPLE_W-1:0]  i_sample,
    output logic                                      o_out_valid,
    input  wire logic                                 i_out_stall,
    output logic signed [swm_pkg::SAMPLE_W-1:0]       o_median,
    output logic                                      o_window_full,
    output logic                                      o_median_changed,
    input  wire logic [swm_pkg::THR_W-1:0]            i_threshold,
    output swm_pkg::t_ram_req                         o_win_req,
    input  wire logic [swm_pkg::SAMPLE_W-1:0]         i_win_rdata,
    output swm_pkg::t_ram_req                         o_srt_req,
    input  wire logic [swm_pkg::SAMPLE_W-1:0]         i_srt_rdata
);

    localparam logic [swm_pkg::CNT_W-1:0] CNT_FULL = swm_pkg::CNT_W'(swm_pkg::WINDOW_LEN);
    localparam logic [swm_pkg::CNT_W-1:0] CNT_LAST = swm_pkg::CNT_W'(swm_pkg::WINDOW_LEN - 1);
    localparam logic [swm_pkg::CNT_W-1:0] CNT_MID  = swm_pkg::CNT_W'(swm_pkg::MID_IDX);
    localparam logic [swm_pkg::IDX_W-1:0] IDX_LAST = swm_pkg::IDX_W'(swm_pkg::WINDOW_LEN - 1);

    swm_pkg::t_state r_state, n_state;

    logic signed [swm_pkg::SAMPLE_W-1:0] r_sample, n_sample;
    logic signed [swm_pkg::SAMPLE_W-1:0] r_old, n_old;
    logic signed [swm_pkg::SAMPLE_W-1:0] r_buf, n_buf;
    logic signed [swm_pkg::SAMPLE_W-1:0] r_median, n_median;
    logic signed [swm_pkg::SAMPLE_W-1:0] r_new_med, n_new_med;
    logic        [swm_pkg::IDX_W-1:0]    r_ptr, n_ptr;
    logic        [swm_pkg::CNT_W-1:0]    r_fill, n_fill;
    logic        [swm_pkg::CNT_W-1:0]    r_rcnt, n_rcnt;
    logic        [swm_pkg::CNT_W-1:0]    r_wcnt, n_wcnt;
    logic                                r_buf_vld, n_buf_vld;
    logic                                r_ins, n_ins;
    logic                                r_rem, n_rem;
    logic                                r_srt_vld, n_srt_vld;
    logic                                r_out_vld, n_out_vld;
    logic signed [swm_pkg::SAMPLE_W-1:0] r_out_med, n_out_med;
    logic                                r_out_full, n_out_full;
    logic                                r_out_chg, n_out_chg;

    logic signed [swm_pkg::SAMPLE_W-1:0] x;
    logic signed [swm_pkg::SAMPLE_W-1:0] med_cand;
    logic signed [swm_pkg::SAMPLE_W:0]   diff;
    logic        [swm_pkg::SAMPLE_W:0]   abs_diff;
    logic        [swm_pkg::CNT_W-1:0]    rcnt_inc;
    logic                                out_free;
    logic                                full;
    logic                                match_old;

    // unwritten sorted entries (before the first pass) read as zero
    assign x         = r_srt_vld ? $signed(i_srt_rdata) : '0;
    assign out_free  = !r_out_vld || !i_out_stall;
    assign full      = (r_fill == CNT_FULL);
    assign rcnt_inc  = r_rcnt + 1'b1;
    assign match_old = !r_rem && (x == r_old);

    always_comb begin
        n_state    = r_state;
        n_sample   = r_sample;
        n_old      = r_old;
        n_buf      = r_buf;
        n_median   = r_median;
        n_new_med  = r_new_med;
        n_ptr      = r_ptr;
        n_fill     = r_fill;
        n_rcnt     = r_rcnt;
        n_wcnt     = r_wcnt;
        n_buf_vld  = r_buf_vld;
        n_ins      = r_ins;
        n_rem      = r_rem;
        n_srt_vld  = r_srt_vld;
        n_out_vld  = r_out_vld && i_out_stall;
        n_out_med  = r_out_med;
        n_out_full = r_out_full;
        n_out_chg  = r_out_chg;
        o_win_req  = '{we: 1'b0, waddr: r_ptr, wdata: r_sample, raddr: r_ptr};
        o_srt_req  = '{we: 1'b0, waddr: r_wcnt[swm_pkg::IDX_W-1:0], wdata: r_sample,
                       raddr: '0};
        med_cand   = r_new_med;
        diff       = '0;
        abs_diff   = '0;

        case (r_state)
            swm_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_sample = i_sample;
                    n_state  = swm_pkg::S_OLD;
                end
            end
            swm_pkg::S_OLD: begin
                // ring read at the write pointer returns the oldest sample
                n_state = swm_pkg::S_LOAD;
            end
            swm_pkg::S_LOAD: begin
                n_old           = (r_fill < CNT_FULL) ? '0 : $signed(i_win_rdata);
                o_win_req.we    = 1'b1;
                n_ptr           = (r_ptr == IDX_LAST) ? '0 : r_ptr + 1'b1;
                n_fill          = (r_fill < CNT_FULL) ? r_fill + 1'b1 : r_fill;
                o_srt_req.raddr = '0;
                n_rcnt          = '0;
                n_wcnt          = '0;
                n_ins           = 1'b0;
                n_rem           = 1'b0;
                n_buf_vld       = 1'b0;
                n_state         = swm_pkg::S_SCAN;
            end
            swm_pkg::S_SCAN: begin
                o_srt_req.raddr = (r_rcnt == CNT_LAST) ? '0 : rcnt_inc[swm_pkg::IDX_W-1:0];
                // merge: drop first copy of the oldest sample, insert the new one
                if (match_old) begin
                    n_rem = 1'b1;
                    if (r_buf_vld) begin
                        o_srt_req.we    = 1'b1;
                        o_srt_req.wdata = r_buf;
                        n_buf_vld       = 1'b0;
                    end
                end else if (!r_ins && (r_sample <= x)) begin
                    o_srt_req.we    = 1'b1;
                    o_srt_req.wdata = r_sample;
                    n_buf           = x;
                    n_buf_vld       = 1'b1;
                    n_ins           = 1'b1;
                end else if (r_buf_vld) begin
                    o_srt_req.we    = 1'b1;
                    o_srt_req.wdata = r_buf;
                    n_buf           = x;
                end else begin
                    o_srt_req.we    = 1'b1;
                    o_srt_req.wdata = x;
                end
                if (r_rcnt == CNT_LAST) begin
                    n_state = swm_pkg::S_DONE;
                end
                n_rcnt = rcnt_inc;
            end
            swm_pkg::S_DONE: begin
                // new sample larger than every kept entry goes to the top;
                // otherwise a still held-back entry fills the top slot
                if (!r_ins) begin
                    o_srt_req.we    = 1'b1;
                    o_srt_req.wdata = r_sample;
                    n_ins           = 1'b1;
                end else if (r_buf_vld) begin
                    o_srt_req.we    = 1'b1;
                    o_srt_req.wdata = r_buf;
                    n_buf_vld       = 1'b0;
                end
                if (o_srt_req.we && (r_wcnt == CNT_MID)) begin
                    med_cand = o_srt_req.wdata;
                end
                diff     = {med_cand[swm_pkg::SAMPLE_W-1], med_cand}
                         - {r_median[swm_pkg::SAMPLE_W-1], r_median};
                abs_diff = diff[swm_pkg::SAMPLE_W] ? unsigned'(-diff) : unsigned'(diff);
                if (out_free) begin
                    n_out_vld  = 1'b1;
                    n_out_full = full;
                    n_out_med  = full ? med_cand : r_median;
                    n_out_chg  = full && (abs_diff > {1'b0, i_threshold});
                    if (full) begin
                        n_median = med_cand;
                    end
                    n_srt_vld = 1'b1;
                    n_state   = swm_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = swm_pkg::S_IDLE;
            end
        endcase

        if (o_srt_req.we) begin
            n_wcnt = r_wcnt + 1'b1;
            if (r_wcnt == CNT_MID) begin
                n_new_med = o_srt_req.wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= swm_pkg::S_IDLE;
            r_ptr     <= '0;
            r_fill    <= '0;
            r_median  <= '0;
            r_srt_vld <= 1'b0;
            r_out_vld <= 1'b0;
            r_rcnt    <= '0;
            r_wcnt    <= '0;
            r_buf_vld <= 1'b0;
            r_ins     <= 1'b0;
            r_rem     <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_ptr     <= n_ptr;
            r_fill    <= n_fill;
            r_median  <= n_median;
            r_srt_vld <= n_srt_vld;
            r_out_vld <= n_out_vld;
            r_rcnt    <= n_rcnt;
            r_wcnt    <= n_wcnt;
            r_buf_vld <= n_buf_vld;
            r_ins     <= n_ins;
            r_rem     <= n_rem;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sample   <= n_sample;
        r_old      <= n_old;
        r_buf      <= n_buf;
        r_new_med  <= n_new_med;
        r_out_med  <= n_out_med;
        r_out_full <= n_out_full;
        r_out_chg  <= n_out_chg;
    end

    assign o_in_stall       = (r_state != swm_pkg::S_IDLE);
    assign o_out_valid      = r_out_vld;
    assign o_median         = r_out_med;
    assign o_window_full    = r_out_full;
    assign o_median_changed = r_out_chg;

endmodule

`default_nettype wire

@@ sv/sliding_window_median_unit.sv @@
// Each accepted item goes through the oldest-sample read, the ring write, the merge pass
// that reads and rewrites the sorted-window memory one entry per cycle, and the result
// step; the input stays stalled until the result has entered the output register.
// A finished result waits in the output register while the next item is taken.
// Reset (synchronous, active low) empties the window, clears fill count and median,
// and loads the change threshold with 3; no clearing pass is needed.
`default_nettype none

`include "sliding_window_median_unit_defines.svh"

module sliding_window_median_unit (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_in_valid,
    output logic                                      o_in_stall,
    input  wire logic signed [swm_pkg::SAMPLE_W-1:0]  i_sample,
    output logic                                      o_out_valid,
    input  wire logic                                 i_out_stall,
    output logic signed [swm_pkg::SAMPLE_W-1:0]       o_median,
    output logic                                      o_window_full,
    output logic                                      o_median_changed,
    input  wire logic                                 psel,
    input  wire logic                                 penable,
    input  wire logic                                 pwrite,
    input  wire logic [swm_pkg::PADDR_W-1:0]          paddr,
    input  wire logic [swm_pkg::PDATA_W-1:0]          pwdata,
    output logic      [swm_pkg::PDATA_W-1:0]          prdata,
    output logic                                      pready
);

    logic [swm_pkg::THR_W-1:0]    threshold;
    swm_pkg::t_ram_req            win_req;
    swm_pkg::t_ram_req            srt_req;
    logic [swm_pkg::SAMPLE_W-1:0] win_rdata;
    logic [swm_pkg::SAMPLE_W-1:0] srt_rdata;

    swm_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .o_threshold (threshold)
    );

    // window samples in arrival order, ring addressed
    swm_ram #(
        .DEPTH (swm_pkg::WINDOW_LEN),
        .WIDTH (swm_pkg::SAMPLE_W),
        .AW    (swm_pkg::IDX_W)
    ) u_win_ram (
        .i_clk   (i_clk),
        .i_we    (win_req.we),
        .i_waddr (win_req.waddr),
        .i_wdata (win_req.wdata),
        .i_raddr (win_req.raddr),
        .o_rdata (win_rdata)
    );

    // same samples kept in ascending order
    swm_ram #(
        .DEPTH (swm_pkg::WINDOW_LEN),
        .WIDTH (swm_pkg::SAMPLE_W),
        .AW    (swm_pkg::IDX_W)
    ) u_srt_ram (
        .i_clk   (i_clk),
        .i_we    (srt_req.we),
        .i_waddr (srt_req.waddr),
        .i_wdata (srt_req.wdata),
        .i_raddr (srt_req.raddr),
        .o_rdata (srt_rdata)
    );

    swm_ctrl u_ctrl (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_sample         (i_sample),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_median         (o_median),
        .o_window_full    (o_window_full),
        .o_median_changed (o_median_changed),
        .i_threshold      (threshold),
        .o_win_req        (win_req),
        .i_win_rdata      (win_rdata),
        .o_srt_req        (srt_req),
        .i_srt_rdata      (srt_rdata)
    );

    `SWM_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && !o_in_stall, o_in_stall, "input not stalled after accepting an item")
    `SWM_ASSERT_NOW(a_chg_needs_full, i_clk, i_rst_n, o_out_valid && o_median_changed, o_window_full, "median change flagged without a full window")
    `SWM_ASSERT_NOW(a_result_from_busy, i_clk, i_rst_n, $rose(o_out_valid), $past(o_in_stall), "result appeared with no item in progress")

endmodule

`default_nettype wire

@@ dv/sliding_window_median_unit_tb.sv @@
// Self-checking testbench for the sliding window median unit
`timescale 1ns / 100ps

module sliding_window_median_unit_tb;
    import swm_pkg::*;

    localparam int CLK_PERIOD  = 12;
    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 300;
    localparam int PHASE_ITEMS = 110;
    localparam int SETTLE      = WINDOW_LEN + 8;

    localparam logic [REG_IDX_W-1:0] REG_UNUSED     = 1'b1;
    localparam logic [PADDR_W-1:0]   ADDR_THRESHOLD = {REG_CHANGE_THRESHOLD, 2'b00};
    localparam logic [PADDR_W-1:0]   ADDR_UNUSED    = {REG_UNUSED, 2'b00};

    localparam logic signed [SAMPLE_W-1:0] S_MAX = 16'sh7FFF;
    localparam logic signed [SAMPLE_W-1:0] S_MIN = 16'sh8000;

    typedef struct {
        logic signed [SAMPLE_W-1:0] median;
        logic                       full;
        logic                       changed;
    } median_res_t;

    class median_scoreboard;
        logic signed [SAMPLE_W-1:0] window [WINDOW_LEN];
        int                         fill;
        logic signed [SAMPLE_W-1:0] median;
        logic [THR_W-1:0]           threshold;
        median_res_t                expected_q [$];
        int                         mismatches;
        int                         results_seen;
        int                         full_seen;
        int                         changed_seen;

        function new();
            foreach (window[i]) window[i] = '0;
            fill         = 0;
            median       = '0;
            threshold    = THR_RESET;
            mismatches   = 0;
            results_seen = 0;
            full_seen    = 0;
            changed_seen = 0;
        endfunction

        function void set_threshold(logic [THR_W-1:0] v);
            threshold = v;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // shift the sample in and work out the result it causes
        function void note_sample(logic signed [SAMPLE_W-1:0] s);
            logic signed [SAMPLE_W-1:0] sorted [WINDOW_LEN];
            logic signed [SAMPLE_W-1:0] t;
            median_res_t                r;
            int                         d;
            for (int i = WINDOW_LEN - 1; i > 0; i--) window[i] = window[i-1];
            window[0] = s;
            if (fill < WINDOW_LEN) fill++;
            r.full    = 1'b0;
            r.changed = 1'b0;
            if (fill == WINDOW_LEN) begin
                sorted = window;
                for (int i = 0; i < WINDOW_LEN - 1; i++) begin
                    for (int j = 0; j < WINDOW_LEN - 1 - i; j++) begin
                        if (sorted[j] > sorted[j+1]) begin
                            t           = sorted[j];
                            sorted[j]   = sorted[j+1];
                            sorted[j+1] = t;
                        end
                    end
                end
                d = int'(sorted[MID_IDX]) - int'(median);
                if (d < 0) d = -d;
                r.full    = 1'b1;
                r.changed = (d > int'(threshold));
                median    = sorted[MID_IDX];
            end
            r.median = median;
            expected_q.push_back(r);
        endfunction

        function void check_result(logic signed [SAMPLE_W-1:0] med, logic full, logic changed);
            median_res_t e;
            results_seen++;
            if (full) full_seen++;
            if (changed) changed_seen++;
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: result with no item pending: median=%0d full=%0b changed=%0b",
                             $realtime, med, full, changed);
                return;
            end
            e = expected_q.pop_front();
            if (med !== e.median || full !== e.full || changed !== e.changed) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: exp med=%0d full=%0b chg=%0b, got med=%0d full=%0b chg=%0b",
                             $realtime, e.median, e.full, e.changed, med, full, changed);
            end
        endfunction
    endclass

    logic                       i_clk       = 1'b0;
    logic                       i_rst_n     = 1'b0;
    logic                       i_in_valid  = 1'b0;
    logic                       o_in_stall;
    logic signed [SAMPLE_W-1:0] i_sample    = '0;
    logic                       o_out_valid;
    logic                       i_out_stall = 1'b0;
    logic signed [SAMPLE_W-1:0] o_median;
    logic                       o_window_full;
    logic                       o_median_changed;
    logic                       psel        = 1'b0;
    logic                       penable     = 1'b0;
    logic                       pwrite      = 1'b0;
    logic [PADDR_W-1:0]         paddr       = '0;
    logic [PDATA_W-1:0]         pwdata      = '0;
    logic [PDATA_W-1:0]         prdata;
    logic                       pready;

    median_scoreboard           sb;
    int                         cycle_cnt   = 0;
    int                         items_sent  = 0;
    int                         thr_writes  = 0;
    int                         hold_reqs   = 0;
    int                         holds_done  = 0;
    bit                         no_idle     = 1'b0;
    logic signed [SAMPLE_W-1:0] drift_base  = '0;
    logic signed [SAMPLE_W-1:0] last_sample = '0;

    sliding_window_median_unit u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_sample         (i_sample),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_median         (o_median),
        .o_window_full    (o_window_full),
        .o_median_changed (o_median_changed),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready)
    );

    initial begin
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    // mostly short gaps, now and then a long one
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // drifting values so the threshold matters, plus full-range noise and extremes
    function automatic logic signed [SAMPLE_W-1:0] next_sample();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) begin
            if ($urandom_range(0, 40) == 0) drift_base = SAMPLE_W'($urandom);
            drift_base = drift_base + $signed(SAMPLE_W'($urandom_range(0, 6))) - 16'sd3;
            return drift_base + $signed(SAMPLE_W'($urandom_range(0, 8))) - 16'sd4;
        end
        if (r < 75) return SAMPLE_W'($urandom);
        if (r < 85) begin
            case ($urandom_range(0, 3))
                0: return S_MAX;
                1: return S_MIN;
                2: return '0;
                default: return -16'sd1;
            endcase
        end
        return last_sample;
    endfunction

    // offer one item and hold it until taken; valid stays high on return
    task automatic send_sample(input logic signed [SAMPLE_W-1:0] s);
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_sample   <= s;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_sample(s);
        last_sample = s;
        items_sent++;
    endtask

    task automatic sender_gap();
        int g;
        g = no_idle ? 0 : gap_len();
        if (g > 0) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            repeat (g - 1) @(negedge i_clk);
        end
    endtask

    task automatic drain();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
    endtask

    task automatic apb_write(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] data);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // registers only change with the block idle
    task automatic write_threshold(input logic [THR_W-1:0] v);
        drain();
        repeat (SETTLE) @(negedge i_clk);
        apb_write(ADDR_THRESHOLD, PDATA_W'(v));
        sb.set_threshold(v);
        thr_writes++;
    endtask

    // receiver: random stalls, long holds on request
    initial begin
        int stall_left;
        int hold_left;
        stall_left = 0;
        hold_left  = 0;
        forever begin
            @(negedge i_clk);
            if (hold_left == 0 && holds_done < hold_reqs) begin
                holds_done++;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                i_out_stall <= 1'b1;
                hold_left--;
            end else if (stall_left > 0) begin
                i_out_stall <= 1'b1;
                stall_left--;
            end else begin
                i_out_stall <= 1'b0;
                if (!no_idle && $urandom_range(0, 4) == 0) stall_left = gap_len();
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            sb.check_result(o_median, o_window_full, o_median_changed);
    end

    initial begin
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("timeout after %0d cycles, %0d items still expected", cycle_cnt, sb.pending());
        $display("[sliding_window_median_unit] ERROR");
        $finish;
    end

    initial begin
        logic [THR_W-1:0] phase_thr [5];
        sb = new();
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // filling window at reset threshold, extremes and toggling bit patterns
        send_sample(S_MAX);
        send_sample(S_MIN);
        send_sample(16'sd0);
        send_sample(-16'sd1);
        send_sample(16'sd1);
        send_sample(16'sd2);
        send_sample(16'sd5);
        send_sample(16'sh5555);
        send_sample(16'shAAAA);
        send_sample(16'sd100);

        // unmapped register must be ignored; largest swing not above max threshold
        drain();
        repeat (SETTLE) @(negedge i_clk);
        apb_write(ADDR_UNUSED, '0);
        write_threshold(16'hFFFF);
        repeat (WINDOW_LEN) send_sample(S_MIN);
        repeat (WINDOW_LEN / 2 + 1) send_sample(S_MAX);
        // same swing back down is just above one less
        write_threshold(16'hFFFE);
        repeat (WINDOW_LEN / 2 + 1) send_sample(S_MIN);

        phase_thr[0] = '0;
        phase_thr[1] = THR_W'($urandom_range(0, 15));
        phase_thr[2] = 16'hFFFF;
        phase_thr[3] = THR_W'($urandom_range(0, 65535));
        phase_thr[4] = THR_RESET;
        for (int p = 0; p < 5; p++) begin
            write_threshold(phase_thr[p]);
            no_idle = (p == 1);
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                if (p == 2 && k == 20) hold_reqs++;
                if (p == 3 && k == 50) drain();
                send_sample(next_sample());
                sender_gap();
            end
        end
        no_idle = 1'b0;

        drain();
        repeat (SETTLE) @(negedge i_clk);
        $display("%0d samples in, %0d results checked, %0d with a full window, %0d change flags",
                 items_sent, sb.results_seen, sb.full_seen, sb.changed_seen);
        $display("%0d threshold settings incl. 0 and 0xFFFF, %0d long output hold(s), %0d errs",
                 thr_writes, holds_done, sb.mismatches);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("[sliding_window_median_unit] OK");
        else
            $display("[sliding_window_median_unit] ERROR");
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+sv
sv/swm_pkg.sv
sv/swm_ram.sv
sv/swm_cfg.sv
sv/swm_ctrl.sv
sv/sliding_window_median_unit.sv
dv/sliding_window_median_unit_tb.sv
